@@ rtl/core/evm_pkg.sv @@
// Shared types and constants for the environment map lookup block.
package evm_pkg;

  // Fixed-point widths
  localparam int DIR_W        = 16;
  localparam int ANG_W        = 20;
  localparam int Z_W          = 22;
  localparam int CD_W         = 27;
  localparam int CORDIC_STEPS = 16;
  localparam int SQ_W         = 31;
  localparam int SQ_STEPS     = 16;
  localparam int ROOT_W       = 15;
  localparam int WXY_W        = 33;

  localparam logic signed [Z_W-1:0]   HALF_TURN   = 22'sd524288;
  localparam logic signed [DIR_W-1:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [DIR_W-1:0] NEG_ONE_Q14 = -16'sd16384;
  localparam logic [28:0]             ONE_SQ      = 29'd268435456;

  // atan(2^-i) in units of 2^-20 turn
  localparam logic [17:0] CORDIC_ANGLE [CORDIC_STEPS] = '{
    18'd131072, 18'd77376, 18'd40883, 18'd20753, 18'd10417, 18'd5213, 18'd2607, 18'd1304,
    18'd652, 18'd326, 18'd163, 18'd81, 18'd41, 18'd20, 18'd10, 18'd5
  };

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic                    req_type;
    logic [8:0]              texel_col;
    logic [7:0]              texel_row;
    logic [15:0]             red_in;
    logic [15:0]             green_in;
    logic [15:0]             blue_in;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } out_t;

  // Control handed from the address pipeline to the memory stage
  typedef struct packed {
    logic valid;
    logic lookup;
    logic wr_en;
    logic empty;
  } ctl_t;

endpackage

@@ rtl/core/evm_ram.sv @@
// Generic single-port RAM with registered read.
module evm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 131072,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/evm_isqrt.sv @@
// Pipelined floor square root, one result bit per stage.
module evm_isqrt (
  input  logic                      clk_i,
  input  logic [28:0]               n_i,
  output logic [evm_pkg::ROOT_W-1:0] root_o
);

  localparam int SW = evm_pkg::SQ_W;
  localparam int NS = evm_pkg::SQ_STEPS;

  logic [SW-1:0] n_q [NS];
  logic [SW-1:0] r_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 1 - 2 * k);
    logic [SW-1:0] n_in;
    logic [SW-1:0] r_in;
    logic [SW-1:0] trial;

    if (k == 0) begin : g_first
      assign n_in = SW'(n_i);
      assign r_in = '0;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + BIT;

    // subtract the trial value when it fits
    always_ff @(posedge clk_i) begin
      if (n_in >= trial) begin
        n_q[k] <= n_in - trial;
        r_q[k] <= (r_in >> 1) + BIT;
      end else begin
        n_q[k] <= n_in;
        r_q[k] <= r_in >> 1;
      end
    end
  end

  assign root_o = r_q[NS-1][evm_pkg::ROOT_W-1:0];

endmodule

@@ rtl/core/evm_cordic.sv @@
// Pipelined vectoring CORDIC: angle of (a, b) in units of 2^-20 turn.
module evm_cordic (
  input  logic                          clk_i,
  input  logic signed [16:0]            a_i,
  input  logic signed [16:0]            b_i,
  output logic signed [evm_pkg::Z_W-1:0] z_o
);

  localparam int CW = evm_pkg::CD_W;
  localparam int ZW = evm_pkg::Z_W;
  localparam int NS = evm_pkg::CORDIC_STEPS;

  logic signed [16:0]   a_sel, b_sel;
  logic signed [CW-1:0] a_w, b_w;
  logic signed [CW-1:0] a0_q, b0_q;
  logic signed [ZW-1:0] z0_q;
  logic signed [CW-1:0] a_q [NS];
  logic signed [CW-1:0] b_q [NS];
  logic signed [ZW-1:0] z_q [NS];

  // left half plane is turned by half a turn first
  assign a_sel = a_i[16] ? -a_i : a_i;
  assign b_sel = a_i[16] ? -b_i : b_i;
  assign a_w   = CW'(a_sel);
  assign b_w   = CW'(b_sel);

  always_ff @(posedge clk_i) begin
    a0_q <= a_w <<< 8;
    b0_q <= b_w <<< 8;
    z0_q <= a_i[16] ? evm_pkg::HALF_TURN : '0;
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = ZW'(evm_pkg::CORDIC_ANGLE[i]);
    logic signed [CW-1:0] a_in, b_in;
    logic signed [ZW-1:0] z_in;

    if (i == 0) begin : g_first
      assign a_in = a0_q;
      assign b_in = b0_q;
      assign z_in = z0_q;
    end else begin : g_next
      assign a_in = a_q[i-1];
      assign b_in = b_q[i-1];
      assign z_in = z_q[i-1];
    end

    // rotation stops once b reaches zero
    always_ff @(posedge clk_i) begin
      if (b_in == '0) begin
        a_q[i] <= a_in;
        b_q[i] <= b_in;
        z_q[i] <= z_in;
      end else if (b_in > 0) begin
        a_q[i] <= a_in + (b_in >>> i);
        b_q[i] <= b_in - (a_in >>> i);
        z_q[i] <= z_in + ANG;
      end else begin
        a_q[i] <= a_in - (b_in >>> i);
        b_q[i] <= b_in + (a_in >>> i);
        z_q[i] <= z_in - ANG;
      end
    end
  end

  assign z_o = z_q[NS-1];

endmodule

@@ rtl/core/evm_blend.sv @@
// Texel memory, four-read sequencer and bilinear accumulation.
module evm_blend #(
  parameter int DEPTH = 131072,
  parameter int CB    = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  evm_pkg::ctl_t                    ctl_i,
  input  logic [AW-1:0]                    wr_addr_i,
  input  logic [3*CB-1:0]                  wr_data_i,
  input  logic [3:0][AW-1:0]               rd_addr_i,
  input  logic [3:0][evm_pkg::WXY_W-1:0]   wxy_i,
  output logic                             done_o,
  output evm_pkg::out_t                    res_o
);

  localparam int TW = 3 * CB;
  localparam int PW = CB + evm_pkg::WXY_W;
  localparam int TOP_W = PW + 1 - 32;
  localparam logic [17:0] CH_MAX = 18'((1 << CB) - 1);
  localparam logic [15:0] EMPTY_VAL = (CH_MAX < 18'd512) ? CH_MAX[15:0] : 16'd512;
  localparam logic [PW:0] ROUND = (PW + 1)'(1) << 31;

  // sequencer
  logic                              act_q, act_d;
  logic [1:0]                        cnt_q, cnt_d;
  logic [3:0][AW-1:0]                addr_q;
  logic [3:0][evm_pkg::WXY_W-1:0]    wxy_q;
  logic                              cap;
  logic                              ram_en, ram_we;
  logic [AW-1:0]                     ram_addr;
  logic [TW-1:0]                     rdata;
  logic                              rd_go;
  logic [1:0]                        rd_k;
  logic                              rdv_q;
  logic [1:0]                        rdk_q;

  // products and sums
  logic [2:0][PW-1:0]                prod_q, acc_q;
  logic                              pv_q;
  logic [1:0]                        pk_q;
  logic                              last_q;
  logic                              done_q;
  evm_pkg::out_t                     res_q;
  logic [2:0][15:0]                  sat;

  always_comb begin
    act_d    = act_q;
    cnt_d    = cnt_q;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = addr_q[cnt_q];
    cap      = 1'b0;
    rd_go    = 1'b0;
    rd_k     = cnt_q;
    if (ctl_i.valid && !ctl_i.lookup) begin
      ram_en   = ctl_i.wr_en;
      ram_we   = ctl_i.wr_en;
      ram_addr = wr_addr_i;
    end else if (ctl_i.valid && !ctl_i.empty) begin
      ram_en   = 1'b1;
      ram_addr = rd_addr_i[0];
      cap      = 1'b1;
      act_d    = 1'b1;
      cnt_d    = 2'd1;
      rd_go    = 1'b1;
      rd_k     = 2'd0;
    end else if (act_q) begin
      ram_en = 1'b1;
      rd_go  = 1'b1;
      cnt_d  = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      cnt_q  <= '0;
      rdv_q  <= 1'b0;
      pv_q   <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      act_q  <= act_d;
      cnt_q  <= cnt_d;
      rdv_q  <= rd_go;
      pv_q   <= rdv_q;
      last_q <= pv_q && (pk_q == 2'd3);
      done_q <= last_q || (ctl_i.valid && ctl_i.lookup && ctl_i.empty);
    end
  end

  // capture neighbor addresses and weights for the whole lookup
  always_ff @(posedge clk_i) begin
    if (cap) begin
      addr_q <= rd_addr_i;
      wxy_q  <= wxy_i;
    end
    rdk_q <= rd_k;
    pk_q  <= rdk_q;
  end

  evm_ram #(
    .WIDTH(TW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(wr_data_i),
    .rdata_o(rdata)
  );

  // weight each texel, then sum the four
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [PW:0]      rnd;
    logic [TOP_W-1:0] top;

    always_ff @(posedge clk_i) begin
      prod_q[c] <= PW'(rdata[c*CB +: CB]) * PW'(wxy_q[rdk_q]);
      if (pv_q) begin
        acc_q[c] <= ((pk_q == 2'd0) ? '0 : acc_q[c]) + prod_q[c];
      end
    end

    assign rnd = (PW + 1)'(acc_q[c]) + ROUND;
    assign top = rnd[PW:32];
    assign sat[c] = (18'(top) > CH_MAX) ? CH_MAX[15:0] : 16'(top);
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (last_q) begin
      res_q.red_out   <= sat[2];
      res_q.green_out <= sat[1];
      res_q.blue_out  <= sat[0];
    end else if (ctl_i.valid && ctl_i.lookup && ctl_i.empty) begin
      res_q.red_out   <= EMPTY_VAL;
      res_q.green_out <= EMPTY_VAL;
      res_q.blue_out  <= EMPTY_VAL;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/core/envmap_direction_bilinear_lookup.sv @@
// Top level of the equirectangular environment map lookup.
//
// Usage:
//   Requests enter on start/req_i and are taken at a clock edge where start is
//   high and busy is low. A write request (req_type 0) stores one texel if it
//   lies inside the image and gives no result; a lookup (req_type 1) gives one
//   result on res_o, shown for exactly one cycle with done_o high.
//   Image size registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   while no request is in flight.
//   Spacing: a write never holds busy, so any request can follow it on the next
//   cycle; a lookup raises busy and blocks every request, so that lookups are
//   spaced to fit the four neighbor reads of the single-port texel memory.
//   The result path runs through the stage 1 register, the square root and
//   CORDIC pipelines (16 and 17 stages), M1 to M3 and the read sequence; when
//   the image is empty the read sequence is skipped.
//   Reset clears the size registers and all valid bits; the texel memory is
//   not cleared and must be written before it is read.
//   The receiver cannot stall; results are never held back.
module envmap_direction_bilinear_lookup #(
  parameter int MAX_WIDTH    = 512,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  evm_pkg::in_t  req_i,
  output logic          done_o,
  output evm_pkg::out_t res_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [9:0]    cfg_wdata_i
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int CB     = CHANNEL_BITS;
  localparam int SD_LEN = 1 + evm_pkg::SQ_STEPS + evm_pkg::CORDIC_STEPS + 1 + 3;
  localparam int IDX_CD = evm_pkg::SQ_STEPS;
  localparam int IDX_M3 = SD_LEN - 2;
  localparam logic [1:0]  LOOKUP_GAP = 2'd3;
  localparam logic [15:0] CH_MAX = 16'((1 << CB) - 1);

  // configuration
  logic [9:0] width_q;
  logic [8:0] height_q;
  logic [9:0] w_eff;
  logic [8:0] h_eff;
  logic       empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == evm_pkg::REG_WIDTH) begin
        width_q <= cfg_wdata_i;
      end else begin
        height_q <= cfg_wdata_i[8:0];
      end
    end
  end

  assign w_eff = (32'(width_q) > MAX_WIDTH) ? 10'(MAX_WIDTH) : width_q;
  assign h_eff = (32'(height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height_q;
  assign empty = (w_eff == '0) || (h_eff == '0);

  // accept and lookup spacing
  logic       accept;
  logic [1:0] hold_q, hold_d;

  assign accept = start && !busy;
  assign busy   = (hold_q != '0);

  always_comb begin
    hold_d = hold_q;
    if (accept && (req_i.req_type == evm_pkg::REQ_LOOKUP)) begin
      hold_d = LOOKUP_GAP;
    end else if (hold_q != '0) begin
      hold_d = hold_q - 2'd1;
    end
  end

  // stage 1: clamp y and form 1 - y^2
  logic signed [15:0] dyc;
  logic signed [31:0] dy2;
  evm_pkg::in_t       side_d;
  logic [28:0]        n1_q;

  always_comb begin
    if ($signed(req_i.dir_y) > evm_pkg::ONE_Q14) begin
      dyc = evm_pkg::ONE_Q14;
    end else if ($signed(req_i.dir_y) < evm_pkg::NEG_ONE_Q14) begin
      dyc = evm_pkg::NEG_ONE_Q14;
    end else begin
      dyc = req_i.dir_y;
    end
    side_d       = req_i;
    side_d.dir_y = dyc;
  end

  assign dy2 = dyc * dyc;

  always_ff @(posedge clk_i) begin
    n1_q <= evm_pkg::ONE_SQ - dy2[28:0];
  end

  // request record and valid bit travel along the pipeline
  evm_pkg::in_t      sd_q [SD_LEN];
  logic [SD_LEN-1:0] vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q   <= '0;
      hold_q <= '0;
    end else begin
      vd_q   <= {vd_q[SD_LEN-2:0], accept};
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= side_d;
    for (int k = 1; k < SD_LEN; k++) begin
      sd_q[k] <= sd_q[k-1];
    end
  end

  // theta = atan2(sqrt(1 - y^2), y), phi = atan2(z, x)
  logic [evm_pkg::ROOT_W-1:0]     root;
  logic signed [evm_pkg::Z_W-1:0] theta_z, phi_z;

  evm_isqrt u_isqrt (
    .clk_i (clk_i),
    .n_i   (n1_q),
    .root_o(root)
  );

  evm_cordic u_theta (
    .clk_i(clk_i),
    .a_i  (17'(sd_q[IDX_CD].dir_y)),
    .b_i  ({2'b00, root}),
    .z_o  (theta_z)
  );

  evm_cordic u_phi (
    .clk_i(clk_i),
    .a_i  (17'(sd_q[IDX_CD].dir_x)),
    .b_i  (17'(sd_q[IDX_CD].dir_z)),
    .z_o  (phi_z)
  );

  // M1: clamp theta, scale both angles by the image size
  logic [19:0] tzc;
  logic [20:0] v_ang;
  logic [29:0] px1_q, py1_q;

  always_comb begin
    if (theta_z < 0) begin
      tzc = '0;
    end else if (theta_z > evm_pkg::HALF_TURN) begin
      tzc = 20'(evm_pkg::HALF_TURN);
    end else begin
      tzc = theta_z[19:0];
    end
  end

  assign v_ang = {tzc, 1'b0};

  always_ff @(posedge clk_i) begin
    px1_q <= 30'(phi_z[19:0]) * 30'(w_eff);
    py1_q <= 30'(v_ang) * 30'(h_eff);
  end

  // M2: wrapped neighbor indices and linear weights
  logic [9:0]  ix, iy, y0, y1p;
  logic [10:0] x1p;
  logic [9:0]  x0_q, x1_q, y0_q, y1_q;
  logic [16:0] wx0_q, wx1_q, wy0_q, wy1_q;

  assign ix  = px1_q[29:20];
  assign iy  = py1_q[29:20];
  assign x1p = {1'b0, ix} + 11'd1;
  assign y0  = (iy >= {1'b0, h_eff}) ? iy - {1'b0, h_eff} : iy;
  assign y1p = y0 + 10'd1;

  always_ff @(posedge clk_i) begin
    x0_q  <= ix;
    x1_q  <= (x1p == {1'b0, w_eff}) ? '0 : x1p[9:0];
    y0_q  <= y0;
    y1_q  <= (y1p == {1'b0, h_eff}) ? '0 : y1p;
    wx0_q <= 17'h10000 - {1'b0, px1_q[19:4]};
    wx1_q <= {1'b0, px1_q[19:4]};
    wy0_q <= 17'h10000 - {1'b0, py1_q[19:4]};
    wy1_q <= {1'b0, py1_q[19:4]};
  end

  // M3: memory addresses, corner weights and the write record
  logic [3:0][AW-1:0]              rd_addr_q;
  logic [3:0][evm_pkg::WXY_W-1:0]  wxy_q;
  logic [33:0]                     w00, w01, w10, w11;
  logic [AW-1:0]                   wr_addr_q;
  logic [3*CB-1:0]                 wr_data_q;
  logic                            wr_en_q;
  evm_pkg::in_t                    wsd;
  logic [2:0][CB-1:0]              wch;
  evm_pkg::ctl_t                   ctl;

  assign w00 = wx0_q * wy0_q;
  assign w01 = wx1_q * wy0_q;
  assign w10 = wx0_q * wy1_q;
  assign w11 = wx1_q * wy1_q;
  assign wsd = sd_q[IDX_M3];

  assign wch[2] = (wsd.red_in > CH_MAX) ? CB'(CH_MAX) : CB'(wsd.red_in);
  assign wch[1] = (wsd.green_in > CH_MAX) ? CB'(CH_MAX) : CB'(wsd.green_in);
  assign wch[0] = (wsd.blue_in > CH_MAX) ? CB'(CH_MAX) : CB'(wsd.blue_in);

  always_ff @(posedge clk_i) begin
    rd_addr_q[0] <= AW'(y0_q) * AW'(MAX_WIDTH) + AW'(x0_q);
    rd_addr_q[1] <= AW'(y0_q) * AW'(MAX_WIDTH) + AW'(x1_q);
    rd_addr_q[2] <= AW'(y1_q) * AW'(MAX_WIDTH) + AW'(x0_q);
    rd_addr_q[3] <= AW'(y1_q) * AW'(MAX_WIDTH) + AW'(x1_q);
    wxy_q[0]     <= w00[evm_pkg::WXY_W-1:0];
    wxy_q[1]     <= w01[evm_pkg::WXY_W-1:0];
    wxy_q[2]     <= w10[evm_pkg::WXY_W-1:0];
    wxy_q[3]     <= w11[evm_pkg::WXY_W-1:0];
    wr_addr_q    <= AW'(wsd.texel_row) * AW'(MAX_WIDTH) + AW'(wsd.texel_col);
    wr_data_q    <= {wch[2], wch[1], wch[0]};
    wr_en_q      <= ({1'b0, wsd.texel_col} < w_eff) && ({1'b0, wsd.texel_row} < h_eff);
  end

  assign ctl.valid  = vd_q[SD_LEN-1];
  assign ctl.lookup = (sd_q[SD_LEN-1].req_type == evm_pkg::REQ_LOOKUP);
  assign ctl.wr_en  = wr_en_q;
  assign ctl.empty  = empty;

  evm_blend #(
    .DEPTH(DEPTH),
    .CB   (CB)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .wr_addr_i(wr_addr_q),
    .wr_data_i(wr_data_q),
    .rd_addr_i(rd_addr_q),
    .wxy_i    (wxy_q),
    .done_o   (done_o),
    .res_o    (res_o)
  );

endmodule

@@ rtl/core/evm_check.sv @@
// Port-level checker for the environment map lookup, bound to the top level.
module evm_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input evm_pkg::in_t  req_i,
  input logic          done_o,
  input evm_pkg::out_t res_o
);

  // an accepted lookup is followed by busy for the whole lookup gap
  a_lookup_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.req_type == evm_pkg::REQ_LOOKUP)) |=> busy ##1 busy ##1 busy)
    else $error("lookup not followed by three busy cycles");

  // busy never lasts beyond the lookup gap
  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy ##1 busy ##1 busy) |=> !busy)
    else $error("busy held longer than the lookup gap");

  // a result is followed by a gap with done_o low, as wide as the lookup gap
  a_done_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o ##1 !done_o ##1 !done_o)
    else $error("results closer than four cycles, res %h", res_o);

endmodule

bind envmap_direction_bilinear_lookup evm_check u_check (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the environment map lookup: texel fills, lookups, size changes.
`timescale 1ns / 100ps

module testbench;

  localparam int MAXW = 512;
  localparam int MAXH = 256;
  localparam int SETTLE = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  evm_pkg::in_t req_i = '0;
  logic done_o;
  evm_pkg::out_t res_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = evm_pkg::REG_WIDTH;
  logic [9:0] cfg_wdata_i = '0;

  envmap_direction_bilinear_lookup dut (.*);

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: image memory and size registers
  logic [47:0] texel_mem [0:MAXW*MAXH-1];
  int unsigned img_w = 0, img_h = 0;
  evm_pkg::in_t pending_reqs[$];
  evm_pkg::out_t expected_colors[$];
  int errors = 0;
  int idle_left = 0;
  bit xfer_seen = 0;

  // atan2(b, a) in 2^-20 turn by vectoring CORDIC
  function automatic longint polar_angle(longint b, longint a);
    longint z, na, nb;
    z = 0;
    if (a == 0 && b == 0) return 0;
    if (a < 0) begin
      a = -a;
      b = -b;
      z = 524288;
    end
    a = a * 256;
    b = b * 256;
    for (int i = 0; i < 16; i++) begin
      if (b == 0) break;
      if (b > 0) begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        z += longint'(evm_pkg::CORDIC_ANGLE[i]);
      end else begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        z -= longint'(evm_pkg::CORDIC_ANGLE[i]);
      end
      a = na;
      b = nb;
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 30;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Apply one accepted transfer to the predictor
  function automatic void predict_transfer(evm_pkg::in_t t);
    longint unsigned w, h, s, u, v, px, py, ix, iy, x0, x1, y0, y1, fx, fy, acc;
    longint dy, tz, pz;
    logic [47:0] t00, t01, t10, t11;
    evm_pkg::out_t o;
    w = (img_w > MAXW) ? MAXW : img_w;
    h = (img_h > MAXH) ? MAXH : img_h;
    if (t.req_type == evm_pkg::REQ_WRITE) begin
      if (t.texel_col < w && t.texel_row < h)
        texel_mem[t.texel_row * MAXW + t.texel_col] = {t.red_in, t.green_in, t.blue_in};
      return;
    end
    if (w == 0 || h == 0) begin
      o = '{16'd512, 16'd512, 16'd512};
      expected_colors.push_back(o);
      return;
    end
    dy = t.dir_y;
    if (dy > 16384) dy = 16384;
    if (dy < -16384) dy = -16384;
    s = floor_sqrt(longint'(268435456) - dy * dy);
    tz = polar_angle(longint'(s), dy);
    if (tz < 0) tz = 0;
    if (tz > 524288) tz = 524288;
    v = tz * 2;
    pz = polar_angle(longint'(t.dir_z), longint'(t.dir_x));
    u = pz & 64'hFFFFF;
    px = u * w;
    py = v * h;
    ix = px >> 20;
    iy = py >> 20;
    x0 = ix % w;
    x1 = (ix + 1) % w;
    y0 = iy % h;
    y1 = (iy + 1) % h;
    fx = (px >> 4) & 64'hFFFF;
    fy = (py >> 4) & 64'hFFFF;
    t00 = texel_mem[y0 * MAXW + x0];
    t01 = texel_mem[y0 * MAXW + x1];
    t10 = texel_mem[y1 * MAXW + x0];
    t11 = texel_mem[y1 * MAXW + x1];
    for (int c = 0; c < 3; c++) begin
      acc = longint'(t00[47-16*c -: 16]) * (65536 - fx) * (65536 - fy)
          + longint'(t01[47-16*c -: 16]) * fx * (65536 - fy)
          + longint'(t10[47-16*c -: 16]) * (65536 - fx) * fy
          + longint'(t11[47-16*c -: 16]) * fx * fy;
      acc = (acc + (64'd1 << 31)) >> 32;
      if (acc > 65535) acc = 65535;
      case (c)
        0: o.red_out = acc[15:0];
        1: o.green_out = acc[15:0];
        default: o.blue_out = acc[15:0];
      endcase
    end
    expected_colors.push_back(o);
  endfunction

  // Transfer detect and result check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      predict_transfer(req_i);
      xfer_seen = 1;
    end
    if (rst_ni && done_o) begin
      if (expected_colors.size() == 0) begin
        $error("result with no lookup outstanding");
        errors++;
      end else begin
        evm_pkg::out_t e;
        e = expected_colors.pop_front();
        if (res_o.red_out !== e.red_out) begin
          $error("red_out exp %0d got %0d", e.red_out, res_o.red_out);
          errors++;
        end
        if (res_o.green_out !== e.green_out) begin
          $error("green_out exp %0d got %0d", e.green_out, res_o.green_out);
          errors++;
        end
        if (res_o.blue_out !== e.blue_out) begin
          $error("blue_out exp %0d got %0d", e.blue_out, res_o.blue_out);
          errors++;
        end
      end
    end
  end

  // Request driver with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!start || xfer_seen)) begin
      xfer_seen = 0;
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_i <= pending_reqs.pop_front();
        start <= 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: idle_left = 0;
          6, 7, 8: idle_left = $urandom_range(1, 3);
          default: idle_left = $urandom_range(10, 40);
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic evm_pkg::in_t rand_fields();
    logic [127:0] r;
    evm_pkg::in_t t;
    r = {$urandom, $urandom, $urandom, $urandom};
    t = r[$bits(evm_pkg::in_t)-1:0];
    return t;
  endfunction

  function automatic evm_pkg::in_t texel_write(int col, int row);
    evm_pkg::in_t t;
    t = rand_fields();
    t.req_type = evm_pkg::REQ_WRITE;
    t.texel_col = 9'(col);
    t.texel_row = 8'(row);
    // random radiance, sometimes red at full scale or green at zero
    if ($urandom_range(0, 7) == 0) t.red_in = '1;
    if ($urandom_range(0, 7) == 0) t.green_in = '0;
    return t;
  endfunction

  function automatic evm_pkg::in_t dir_lookup(int x, int y, int z);
    evm_pkg::in_t t;
    t = rand_fields();
    t.req_type = evm_pkg::REQ_LOOKUP;
    t.dir_x = 16'(x);
    t.dir_y = 16'(y);
    t.dir_z = 16'(z);
    return t;
  endfunction

  // Mostly unit directions, the rest arbitrary 16-bit vectors
  function automatic evm_pkg::in_t rand_lookup();
    real th, ph;
    evm_pkg::in_t t;
    if ($urandom_range(0, 9) < 7) begin
      th = 3.14159265 * $urandom_range(0, 100000) / 100000.0;
      ph = 6.28318531 * $urandom_range(0, 100000) / 100000.0;
      t = dir_lookup($rtoi(16384.0 * $sin(th) * $cos(ph)), $rtoi(16384.0 * $cos(th)),
                     $rtoi(16384.0 * $sin(th) * $sin(ph)));
    end else begin
      t = rand_fields();
      t.req_type = evm_pkg::REQ_LOOKUP;
    end
    return t;
  endfunction

  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || start || expected_colors.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(evm_pkg::reg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= 10'(val);
    if (idx == evm_pkg::REG_WIDTH) img_w = val & 32'h3FF; else img_h = val & 32'h1FF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Set a size, fill the visible image, then queue lookups and stray writes
  task automatic run_phase(int unsigned w, int unsigned h, int n_rand);
    int unsigned cw, ch;
    drain();
    write_reg(evm_pkg::REG_WIDTH, w);
    write_reg(evm_pkg::REG_HEIGHT, h);
    cw = (w > MAXW) ? MAXW : w;
    ch = (h > MAXH) ? MAXH : h;
    if (cw != 0 && ch != 0)
      for (int r = 0; r < ch; r++)
        for (int c = 0; c < cw; c++)
          pending_reqs.push_back(texel_write(c, r));
    for (int i = 0; i < n_rand; i++) begin
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(texel_write($urandom_range(0, 511), $urandom_range(0, 255)));
        1: if (cw != 0 && ch != 0)
             pending_reqs.push_back(texel_write($urandom_range(0, cw - 1),
                                                $urandom_range(0, ch - 1)));
        default: pending_reqs.push_back(rand_lookup());
      endcase
    end
  endtask

  // Stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty image: default color, writes ignored
    run_phase(0, 0, 0);
    pending_reqs.push_back(texel_write(0, 0));
    pending_reqs.push_back(dir_lookup(16384, 0, 0));
    run_phase(0, 5, 6);
    run_phase(3, 0, 6);

    // directed lookups: axes, poles, zero vector, extremes, whole-coordinate points
    run_phase(4, 2, 0);
    pending_reqs.push_back(texel_write(4, 0));
    pending_reqs.push_back(texel_write(0, 2));
    pending_reqs.push_back(dir_lookup(16384, 0, 0));
    pending_reqs.push_back(dir_lookup(-16384, 0, 0));
    pending_reqs.push_back(dir_lookup(0, 0, 16384));
    pending_reqs.push_back(dir_lookup(0, 0, -16384));
    pending_reqs.push_back(dir_lookup(0, 16384, 0));
    pending_reqs.push_back(dir_lookup(0, -16384, 0));
    pending_reqs.push_back(dir_lookup(0, 0, 0));
    pending_reqs.push_back(dir_lookup(-32768, 32767, -32768));
    pending_reqs.push_back(dir_lookup(32767, -32768, 32767));
    pending_reqs.push_back(dir_lookup(-16384, 0, -1));
    pending_reqs.push_back(dir_lookup(11585, 11585, 0));

    // single texel, and a height above the maximum
    run_phase(1, 1, 20);
    run_phase(1, 300, 20);

    // random bulk
    run_phase(7, 4, 80);
    run_phase(2, 3, 40);
    run_phase(16, 8, 100);
    run_phase(0, 0, 10);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
